// ----- rtl/ngfp_pkg.sv -----
// ----------------------------------------------------------------------------
// ngfp_pkg
// Shared constants, types and helpers for the GGA fix parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ngfp_pkg;

   localparam int LINE_LIMIT      = 128;
   localparam int FIELD_LIMIT     = 15;
   localparam int MIN_FRAC_DIGITS = 5;

   function automatic longint unsigned pow10(input int n);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < n; i++) p = p * 10;
      return p;
   endfunction

   localparam int LC_W  = $clog2(LINE_LIMIT);
   localparam int FCC_W = $clog2(FIELD_LIMIT + 2);
   localparam int ACC_W = 40;

   localparam longint unsigned COORD_CAP  = 64'd999999999999;
   localparam longint unsigned FRAC_SCALE = pow10(MIN_FRAC_DIGITS);
   localparam longint unsigned DEG_UNIT   = 100 * FRAC_SCALE;
   localparam longint unsigned HI_MAX     = COORD_CAP / DEG_UNIT;
   localparam longint unsigned CAP_M      = COORD_CAP % DEG_UNIT;
   localparam longint unsigned MIN_K      = pow10(7 - MIN_FRAC_DIGITS);
   localparam longint unsigned E7         = 64'd10000000;
   localparam longint unsigned LAT_LIMIT  = 64'd900000000;
   localparam longint unsigned LON_LIMIT  = 64'd1800000000;
   localparam longint unsigned LAT_DEG    = LAT_LIMIT / E7;
   localparam longint unsigned LON_DEG    = LON_LIMIT / E7;
   localparam longint unsigned RECIP15    = 64'd286331154;

   localparam int HI_W   = $clog2(HI_MAX + 1);
   localparam int FRAC_W = $clog2(FRAC_SCALE);
   localparam int M_W    = $clog2(DEG_UNIT);
   localparam int DEG_W  = $clog2(LON_DEG + 2);
   localparam int Y_W    = 30;
   localparam int R_W    = 25;

   localparam int TIME_MAX = 999999;
   localparam int HDOP_MAX = 9999;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_SIGNED,
      PH_INT,
      PH_FRAC,
      PH_STOP
   } scan_phase_type;

   typedef struct packed {
      logic              sat;
      logic [HI_W-1:0]   hi;
      logic [3:0]        tens;
      logic [3:0]        ones;
      logic [FRAC_W-1:0] frac;
      logic              neg;
   } coord_type;

   typedef struct packed {
      logic        fix;
      coord_type   lat;
      coord_type   lon;
      logic [19:0] tm;
      logic [13:0] hdop;
   } line_rec_type;

endpackage

`default_nettype wire

// ----- rtl/ngfp_front.sv -----
// ----------------------------------------------------------------------------
// ngfp_front
// Byte-level line scanner: header check, field split, digit accumulation.
// Emits one line record per qualifying newline.
// ----------------------------------------------------------------------------
`default_nettype none

module ngfp_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire logic [7:0]             in_byte,
   output logic                        rec_valid,
   output ngfp_pkg::line_rec_type      rec
);

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_DOLR  = 8'h24;
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_W     = 8'h57;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [2:0] F_TIME = 3'd0;
   localparam logic [2:0] F_LAT  = 3'd1;
   localparam logic [2:0] F_NS   = 3'd2;
   localparam logic [2:0] F_LON  = 3'd3;
   localparam logic [2:0] F_EW   = 3'd4;
   localparam logic [2:0] F_QUAL = 3'd5;
   localparam logic [2:0] F_HDOP = 3'd6;

   localparam logic [1:0] K_NONE = 2'd0;
   localparam logic [1:0] K_INT  = 2'd1;
   localparam logic [1:0] K_FRAC = 2'd2;

   typedef struct packed {
      ngfp_pkg::scan_phase_type ph;
      logic                     neg;
      logic                     dig;
      logic [1:0]               kind;
   } scan_res_type;

   function automatic scan_res_type scan_step(ngfp_pkg::scan_phase_type ph, logic neg,
                                              logic dig, logic [7:0] c, logic allow_frac);
      scan_res_type r;
      logic         is_dig;
      logic         cont;
      r.ph   = ph;
      r.neg  = neg;
      r.dig  = dig;
      r.kind = K_NONE;
      is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
      cont   = 1'b1;
      if (ph == ngfp_pkg::PH_LEAD) begin
         if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
            cont = 1'b0;
         end else begin
            r.ph = ngfp_pkg::PH_SIGNED;
            if (c == CH_PLUS || c == CH_MINUS) begin
               r.neg = (c == CH_MINUS);
               cont  = 1'b0;
            end
         end
      end
      if (cont && (r.ph == ngfp_pkg::PH_SIGNED || r.ph == ngfp_pkg::PH_INT)) begin
         if (is_dig) begin
            r.ph   = ngfp_pkg::PH_INT;
            r.dig  = 1'b1;
            r.kind = K_INT;
         end else if (c == CH_DOT && allow_frac) begin
            r.ph = ngfp_pkg::PH_FRAC;
         end else begin
            r.ph = ngfp_pkg::PH_STOP;
         end
      end else if (cont && r.ph == ngfp_pkg::PH_FRAC) begin
         if (is_dig) begin
            r.dig  = 1'b1;
            r.kind = K_FRAC;
         end else begin
            r.ph = ngfp_pkg::PH_STOP;
         end
      end
      return r;
   endfunction

   function automatic logic [ngfp_pkg::ACC_W-1:0] frac_weight(logic [3:0] d, logic [2:0] fc);
      logic [ngfp_pkg::ACC_W-1:0] w;
      w = '0;
      for (int i = 0; i < ngfp_pkg::MIN_FRAC_DIGITS; i++) begin
         if (fc == 3'(i)) begin
            w = ngfp_pkg::ACC_W'(d) *
                ngfp_pkg::ACC_W'(ngfp_pkg::pow10(ngfp_pkg::MIN_FRAC_DIGITS - 1 - i));
         end
      end
      return w;
   endfunction

   logic [ngfp_pkg::LC_W-1:0]  lc_ff, lc_in;
   logic [2:0]                 fn_ff, fn_in;
   logic [ngfp_pkg::FCC_W-1:0] fcc_ff, fcc_in;
   logic                       hdr_ff, hdr_in;
   logic                       syn_ff, syn_in;
   logic [19:0]                tm_ff, tm_in;
   logic [ngfp_pkg::ACC_W-1:0] acc_ff [2];
   logic [ngfp_pkg::ACC_W-1:0] acc_in [2];
   ngfp_pkg::coord_type        crd_ff [2];
   ngfp_pkg::coord_type        crd_in [2];
   logic [1:0]                 hemi_ff, hemi_in;
   logic                       qnz_ff, qnz_in;
   logic                       qclean_ff, qclean_in;
   logic [6:0]                 qwhole_ff, qwhole_in;
   logic [6:0]                 qfrac_ff, qfrac_in;
   ngfp_pkg::scan_phase_type   ph_ff, ph_in;
   logic [2:0]                 fc_ff, fc_in;
   logic                       sneg_ff, sneg_in;
   logic                       sdig_ff, sdig_in;
   logic                       line_clr;

   always_comb begin : front_next
      scan_res_type               sc;
      logic                       lane;
      logic [3:0]                 dgt;
      logic [43:0]                s;
      logic [ngfp_pkg::ACC_W-1:0] w;
      logic [ngfp_pkg::HI_W+3:0]  hi_x;
      logic [23:0]                t;
      logic [9:0]                 qw;
      logic [13:0]                hd;
      logic                       hdr_ok;
      logic                       syn_eff;
      logic [ngfp_pkg::FCC_W-1:0] lim;

      lc_in     = lc_ff;
      fn_in     = fn_ff;
      fcc_in    = fcc_ff;
      hdr_in    = hdr_ff;
      syn_in    = syn_ff;
      tm_in     = tm_ff;
      acc_in    = acc_ff;
      crd_in    = crd_ff;
      hemi_in   = hemi_ff;
      qnz_in    = qnz_ff;
      qclean_in = qclean_ff;
      qwhole_in = qwhole_ff;
      qfrac_in  = qfrac_ff;
      ph_in     = ph_ff;
      fc_in     = fc_ff;
      sneg_in   = sneg_ff;
      sdig_in   = sdig_ff;
      line_clr  = 1'b0;
      rec_valid = 1'b0;
      rec       = '0;

      sc   = scan_step(ph_ff, sneg_ff, sdig_ff, in_byte,
                       (fn_ff == F_LAT) || (fn_ff == F_LON) || (fn_ff == F_HDOP));
      lane = (fn_ff == F_LON);
      dgt  = in_byte[3:0];
      s    = '0;
      w    = '0;
      hi_x = '0;
      t    = '0;
      qw   = '0;
      hd   = '0;
      lim  = (fn_ff == F_NS || fn_ff == F_EW) ? ngfp_pkg::FCC_W'(1)
                                              : ngfp_pkg::FCC_W'(ngfp_pkg::FIELD_LIMIT);
      syn_eff = syn_ff && !((fn_ff == F_QUAL) &&
                ((fcc_ff > ngfp_pkg::FCC_W'(ngfp_pkg::FIELD_LIMIT)) || !sdig_ff));

      case (lc_ff)
         ngfp_pkg::LC_W'(0): hdr_ok = (in_byte == CH_DOLR);
         ngfp_pkg::LC_W'(2): hdr_ok = (in_byte == CH_P) || (in_byte == CH_N);
         ngfp_pkg::LC_W'(5): hdr_ok = (in_byte == CH_A);
         default:            hdr_ok = (in_byte == CH_G);
      endcase

      if (in_valid) begin
         if (in_byte == CH_CR) begin
            lc_in = lc_ff;
         end else if (in_byte == CH_LF) begin
            line_clr  = 1'b1;
            rec_valid = hdr_ff && (lc_ff > ngfp_pkg::LC_W'(6));
            hd = 14'(qwhole_ff) * 14'd100 + 14'(qfrac_ff);
            if (hd > 14'(ngfp_pkg::HDOP_MAX)) hd = 14'(ngfp_pkg::HDOP_MAX);
            rec.fix     = syn_eff && (fn_ff == F_QUAL || fn_ff == F_HDOP) && qnz_ff;
            rec.lat     = crd_ff[0];
            rec.lat.neg = hemi_ff[0];
            rec.lon     = crd_ff[1];
            rec.lon.neg = hemi_ff[1];
            rec.tm      = tm_ff;
            rec.hdop    = (fn_ff == F_HDOP && qclean_ff && sdig_ff && !sneg_ff) ? hd : 14'd0;
         end else if (lc_ff < ngfp_pkg::LC_W'(ngfp_pkg::LINE_LIMIT - 1)) begin
            lc_in = lc_ff + 1'b1;
            if (lc_ff < ngfp_pkg::LC_W'(6)) begin
               if (lc_ff == '0) begin
                  hdr_in = hdr_ok;
                  syn_in = 1'b0;
               end else if (!hdr_ok) begin
                  hdr_in = 1'b0;
               end
            end else if (lc_ff == ngfp_pkg::LC_W'(6)) begin
               if (in_byte == CH_COMMA) syn_in = 1'b1;
            end else if (syn_ff) begin
               if (fn_ff == F_HDOP) begin
                  ph_in   = sc.ph;
                  sneg_in = sc.neg;
                  sdig_in = sc.dig;
                  if (sc.kind == K_INT) begin
                     qw = 10'(qwhole_ff) * 10'd10 + 10'(dgt);
                     qwhole_in = (qw > 10'd100) ? 7'd100 : qw[6:0];
                  end else if (sc.kind == K_FRAC) begin
                     if (fc_ff == 3'd0) qfrac_in = qfrac_ff + 7'(dgt) * 7'd10;
                     else if (fc_ff == 3'd1) qfrac_in = qfrac_ff + 7'(dgt);
                     if (fc_ff != 3'd7) fc_in = fc_ff + 3'd1;
                  end
               end else if (fn_ff < F_HDOP) begin
                  if (in_byte == CH_COMMA) begin
                     if (fn_ff <= F_EW) begin
                        if (fcc_ff == '0 || fcc_ff > lim) syn_in = 1'b0;
                        if (fn_ff == F_TIME && sneg_ff) tm_in = '0;
                        if (fn_ff == F_LAT && sneg_ff) hemi_in[0] = ~hemi_ff[0];
                        if (fn_ff == F_LON && sneg_ff) hemi_in[1] = ~hemi_ff[1];
                     end else begin
                        if (fcc_ff > ngfp_pkg::FCC_W'(ngfp_pkg::FIELD_LIMIT) || !sdig_ff)
                           syn_in = 1'b0;
                        qclean_in = (ph_ff == ngfp_pkg::PH_INT);
                     end
                     fn_in   = fn_ff + 3'd1;
                     fcc_in  = '0;
                     ph_in   = ngfp_pkg::PH_LEAD;
                     fc_in   = '0;
                     sneg_in = 1'b0;
                     sdig_in = 1'b0;
                  end else begin
                     if (fn_ff == F_NS && fcc_ff == '0 && in_byte == CH_S)
                        hemi_in[0] = ~hemi_ff[0];
                     if (fn_ff == F_EW && fcc_ff == '0 && in_byte == CH_W)
                        hemi_in[1] = ~hemi_ff[1];
                     if (fcc_ff <= ngfp_pkg::FCC_W'(ngfp_pkg::FIELD_LIMIT))
                        fcc_in = fcc_ff + 1'b1;
                     if (fn_ff == F_TIME) begin
                        ph_in   = sc.ph;
                        sneg_in = sc.neg;
                        sdig_in = sc.dig;
                        if (sc.kind == K_INT) begin
                           t = 24'(tm_ff) * 24'd10 + 24'(dgt);
                           tm_in = (t > 24'(ngfp_pkg::TIME_MAX)) ? 20'(ngfp_pkg::TIME_MAX)
                                                                 : t[19:0];
                        end
                     end else if (fn_ff == F_LAT || fn_ff == F_LON) begin
                        ph_in   = sc.ph;
                        sneg_in = sc.neg;
                        sdig_in = sc.dig;
                        if (sc.kind == K_INT && !crd_ff[lane].sat) begin
                           s = (44'(acc_ff[lane]) << 3) + (44'(acc_ff[lane]) << 1) +
                               44'(dgt) * 44'(ngfp_pkg::FRAC_SCALE);
                           if (s > 44'(ngfp_pkg::COORD_CAP)) begin
                              crd_in[lane].sat = 1'b1;
                           end else begin
                              hi_x = ((ngfp_pkg::HI_W+4)'(crd_ff[lane].hi) << 3) +
                                     ((ngfp_pkg::HI_W+4)'(crd_ff[lane].hi) << 1) +
                                     (ngfp_pkg::HI_W+4)'(crd_ff[lane].tens);
                              acc_in[lane]      = s[ngfp_pkg::ACC_W-1:0];
                              crd_in[lane].hi   = hi_x[ngfp_pkg::HI_W-1:0];
                              crd_in[lane].tens = crd_ff[lane].ones;
                              crd_in[lane].ones = dgt;
                           end
                        end else if (sc.kind == K_FRAC) begin
                           if (fc_ff < 3'(ngfp_pkg::MIN_FRAC_DIGITS) && !crd_ff[lane].sat)
                           begin
                              w = frac_weight(dgt, fc_ff);
                              s = 44'(acc_ff[lane]) + 44'(w);
                              if (s > 44'(ngfp_pkg::COORD_CAP)) begin
                                 crd_in[lane].sat = 1'b1;
                              end else begin
                                 acc_in[lane]      = s[ngfp_pkg::ACC_W-1:0];
                                 crd_in[lane].frac = crd_ff[lane].frac +
                                                     w[ngfp_pkg::FRAC_W-1:0];
                              end
                           end
                           if (fc_ff != 3'd7) fc_in = fc_ff + 3'd1;
                        end
                     end else if (fn_ff == F_QUAL) begin
                        ph_in   = sc.ph;
                        sneg_in = sc.neg;
                        sdig_in = sc.dig;
                        if (sc.kind == K_INT && dgt != 4'd0) qnz_in = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || line_clr) begin
         lc_ff     <= '0;
         fn_ff     <= '0;
         fcc_ff    <= '0;
         hdr_ff    <= 1'b0;
         syn_ff    <= 1'b0;
         tm_ff     <= '0;
         acc_ff    <= '{default: '0};
         crd_ff    <= '{default: '0};
         hemi_ff   <= '0;
         qnz_ff    <= 1'b0;
         qclean_ff <= 1'b0;
         qwhole_ff <= '0;
         qfrac_ff  <= '0;
         ph_ff     <= ngfp_pkg::PH_LEAD;
         fc_ff     <= '0;
         sneg_ff   <= 1'b0;
         sdig_ff   <= 1'b0;
      end else begin
         lc_ff     <= lc_in;
         fn_ff     <= fn_in;
         fcc_ff    <= fcc_in;
         hdr_ff    <= hdr_in;
         syn_ff    <= syn_in;
         tm_ff     <= tm_in;
         acc_ff    <= acc_in;
         crd_ff    <= crd_in;
         hemi_ff   <= hemi_in;
         qnz_ff    <= qnz_in;
         qclean_ff <= qclean_in;
         qwhole_ff <= qwhole_in;
         qfrac_ff  <= qfrac_in;
         ph_ff     <= ph_in;
         fc_ff     <= fc_in;
         sneg_ff   <= sneg_in;
         sdig_ff   <= sdig_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      lc_ff <= ngfp_pkg::LC_W'(ngfp_pkg::LINE_LIMIT - 1))
      else $error("line count past limit");

   assert property (@(posedge clock) disable iff (reset)
      fn_ff <= F_HDOP)
      else $error("field number past hdop");

   assert property (@(posedge clock) disable iff (reset)
      (qwhole_ff <= 7'd100) && (qfrac_ff <= 7'd99))
      else $error("hdop parts out of range");

endmodule

`default_nettype wire

// ----- rtl/ngfp_queue.sv -----
// ----------------------------------------------------------------------------
// ngfp_queue
// Small line record queue between the scanner and the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module ngfp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  ngfp_pkg::line_rec_type      wr_data,
   output logic                        full,
   input  wire logic                   rd_en,
   output ngfp_pkg::line_rec_type      rd_data,
   output logic                        empty
);

   ngfp_pkg::line_rec_type      mem_ff [ngfp_pkg::QUEUE_DEPTH];
   logic [ngfp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ngfp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ngfp_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic                        do_wr, do_rd;

   assign full    = (cnt_ff == ngfp_pkg::QCNT_W'(ngfp_pkg::QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + ngfp_pkg::QCNT_W'(do_wr) - ngfp_pkg::QCNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !(wr_en && full))
      else $error("record written into full queue");

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= ngfp_pkg::QCNT_W'(ngfp_pkg::QUEUE_DEPTH))
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0 && cnt_ff != ngfp_pkg::QCNT_W'(ngfp_pkg::QUEUE_DEPTH)) |->
      (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- rtl/ngfp_back.sv -----
// ----------------------------------------------------------------------------
// ngfp_back
// Four stage converter: ddmm.mmmmm records to 1e-7 degree results.
// Minute part divided by 60 through a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module ngfp_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   rec_avail,
   input  ngfp_pkg::line_rec_type      rec,
   output logic                        rec_take,
   output logic                        out_valid,
   input  wire logic                   out_take,
   output logic                        out_fix,
   output logic signed [30:0]          out_lat,
   output logic signed [31:0]          out_lon,
   output logic [13:0]                 out_hdop,
   output logic [19:0]                 out_time
);

   typedef struct packed {
      logic        fix;
      logic [1:0]  neg;
      logic [19:0] tm;
      logic [13:0] hdop;
   } meta_type;

   function automatic logic [ngfp_pkg::M_W-1:0] minute_part(ngfp_pkg::coord_type c);
      logic [ngfp_pkg::M_W-1:0] m;
      if (c.sat) begin
         m = ngfp_pkg::M_W'(ngfp_pkg::CAP_M);
      end else begin
         m = ngfp_pkg::M_W'(c.tens) * ngfp_pkg::M_W'(10) + ngfp_pkg::M_W'(c.ones);
         m = m * ngfp_pkg::M_W'(ngfp_pkg::FRAC_SCALE) + ngfp_pkg::M_W'(c.frac);
      end
      return m;
   endfunction

   function automatic logic [31:0] degree_term(ngfp_pkg::coord_type c,
                                               logic [ngfp_pkg::DEG_W-1:0] deg);
      logic [ngfp_pkg::HI_W-1:0]  hi;
      logic [ngfp_pkg::DEG_W-1:0] hc;
      hi = c.sat ? ngfp_pkg::HI_W'(ngfp_pkg::HI_MAX) : c.hi;
      hc = (hi > ngfp_pkg::HI_W'(deg)) ? deg + 1'b1 : ngfp_pkg::DEG_W'(hi);
      return 32'(hc) * 32'(ngfp_pkg::E7);
   endfunction

   logic                       adv;
   logic                       v1_ff, v2_ff, v3_ff, v4_ff;
   meta_type                   m1_ff, m2_ff, m3_ff;
   logic [ngfp_pkg::M_W-1:0]   min1_ff [2];
   logic [31:0]                d1_ff [2];
   logic [31:0]                d2_ff [2];
   logic [31:0]                d3_ff [2];
   logic [ngfp_pkg::Y_W-1:0]   y2_ff [2];
   logic [ngfp_pkg::R_W-1:0]   r3_ff [2];
   logic                       fix_ff;
   logic signed [30:0]         lat_ff;
   logic signed [31:0]         lon_ff;
   logic [13:0]                hdop_ff;
   logic [19:0]                time_ff;
   logic [32:0]                mag_lat, mag_lon;
   logic [31:0]                lat_clip, lon_clip;

   assign adv      = !v4_ff || out_take;
   assign rec_take = adv && rec_avail;

   always_comb begin
      mag_lat  = 33'(d3_ff[0]) + 33'(r3_ff[0]);
      mag_lon  = 33'(d3_ff[1]) + 33'(r3_ff[1]);
      lat_clip = (mag_lat > 33'(ngfp_pkg::LAT_LIMIT)) ? 32'(ngfp_pkg::LAT_LIMIT)
                                                      : mag_lat[31:0];
      lon_clip = (mag_lon > 33'(ngfp_pkg::LON_LIMIT)) ? 32'(ngfp_pkg::LON_LIMIT)
                                                      : mag_lon[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= rec_avail;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff.fix  <= rec.fix;
         m1_ff.neg  <= {rec.lon.neg, rec.lat.neg};
         m1_ff.tm   <= rec.tm;
         m1_ff.hdop <= rec.hdop;
         min1_ff[0] <= minute_part(rec.lat);
         min1_ff[1] <= minute_part(rec.lon);
         d1_ff[0]   <= degree_term(rec.lat, ngfp_pkg::DEG_W'(ngfp_pkg::LAT_DEG));
         d1_ff[1]   <= degree_term(rec.lon, ngfp_pkg::DEG_W'(ngfp_pkg::LON_DEG));

         m2_ff <= m1_ff;
         d2_ff <= d1_ff;
         for (int i = 0; i < 2; i++) begin
            y2_ff[i] <= ngfp_pkg::Y_W'(64'(min1_ff[i]) * 64'(ngfp_pkg::MIN_K) + 64'd30);
         end

         m3_ff <= m2_ff;
         d3_ff <= d2_ff;
         for (int i = 0; i < 2; i++) begin
            r3_ff[i] <= ngfp_pkg::R_W'((64'(y2_ff[i][ngfp_pkg::Y_W-1:2]) *
                                        64'(ngfp_pkg::RECIP15)) >> 32);
         end

         fix_ff  <= m3_ff.fix;
         lat_ff  <= !m3_ff.fix ? '0 :
                    m3_ff.neg[0] ? 31'(32'd0 - lat_clip) : 31'(lat_clip);
         lon_ff  <= !m3_ff.fix ? '0 :
                    m3_ff.neg[1] ? 32'd0 - lon_clip : lon_clip;
         hdop_ff <= m3_ff.fix ? m3_ff.hdop : '0;
         time_ff <= m3_ff.fix ? m3_ff.tm : '0;
      end
   end

   assign out_valid = v4_ff;
   assign out_fix   = fix_ff;
   assign out_lat   = lat_ff;
   assign out_lon   = lon_ff;
   assign out_hdop  = hdop_ff;
   assign out_time  = time_ff;

   assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !fix_ff) |-> (lat_ff == '0 && lon_ff == '0 && hdop_ff == '0 && time_ff == '0))
      else $error("no-fix result carries data");

   assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> (lat_ff <= $signed(31'(ngfp_pkg::LAT_LIMIT)) &&
                 lat_ff >= -$signed(31'(ngfp_pkg::LAT_LIMIT))))
      else $error("latitude outside limit");

   assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> (hdop_ff <= 14'(ngfp_pkg::HDOP_MAX) && time_ff <= 20'(ngfp_pkg::TIME_MAX)))
      else $error("hdop or time outside limit");

   assert property (@(posedge clock) disable iff (reset)
      (v3_ff && v4_ff && !out_take) |=> (v3_ff && v4_ff))
      else $error("stalled converter lost a record");

endmodule

`default_nettype wire

// ----- rtl/nmea_gga_fix_parser.sv -----
// ----------------------------------------------------------------------------
// nmea_gga_fix_parser
// GGA parser: one byte per cycle in unless full, one fix/no-fix result per GGA line.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; full rises only when four line results wait
//   behind a result port that is not being popped.
// Path: the result of a newline transfer goes through the record queue, then the
//   four converter stages with the divide by 60, to the rsp_ ports.
// Reset: synchronous; clears the line scanner, the record queue and the converter.
`default_nettype none

module nmea_gga_fix_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic [7:0]         req_rx_byte,
   output logic                    empty,
   input  wire logic               pop,
   output logic                    rsp_fix_valid,
   output logic signed [30:0]      rsp_latitude_e7,
   output logic signed [31:0]      rsp_longitude_e7,
   output logic [13:0]             rsp_hdop_centi,
   output logic [19:0]             rsp_time_hhmmss
);

   logic                   q_full;
   logic                   q_empty;
   logic                   q_take;
   logic                   rec_valid;
   ngfp_pkg::line_rec_type rec;
   ngfp_pkg::line_rec_type q_head;
   logic                   out_valid;

   assign full = q_full;

   ngfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push && !q_full),
      .in_byte   (req_rx_byte),
      .rec_valid (rec_valid),
      .rec       (rec)
   );

   ngfp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rec_valid),
      .wr_data (rec),
      .full    (q_full),
      .rd_en   (q_take),
      .rd_data (q_head),
      .empty   (q_empty)
   );

   ngfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_avail (!q_empty),
      .rec       (q_head),
      .rec_take  (q_take),
      .out_valid (out_valid),
      .out_take  (pop),
      .out_fix   (rsp_fix_valid),
      .out_lat   (rsp_latitude_e7),
      .out_lon   (rsp_longitude_e7),
      .out_hdop  (rsp_hdop_centi),
      .out_time  (rsp_time_hhmmss)
   );

   assign empty = !out_valid;

endmodule

`default_nettype wire

// ----- test/tb_nmea_gga_fix_parser.sv -----
// ----------------------------------------------------------------------------
// tb_nmea_gga_fix_parser
// Drives GGA byte streams through the parser and checks each fix or no-fix
// result against a cycle-free model of the line scanner and the conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_nmea_gga_fix_parser;

   localparam int                    WATCHDOG_LIMIT = 20000;
   localparam int                    FRAC_DIGITS    = 5;
   localparam longint unsigned       ACC_CAP        = 64'd999999999999;
   localparam int                    HOLD_CYCLES    = 400;

   typedef struct packed {
      logic        fix;
      logic [30:0] lat;
      logic [31:0] lon;
      logic [13:0] hdop;
      logic [19:0] tm;
   } fix_rec_type;

   typedef struct {
      string       text;
      logic        has_fix;
      fix_rec_type rec;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        pop = 1'b0;
   logic        full, empty, rsp_fix_valid;
   logic signed [30:0] rsp_latitude_e7;
   logic signed [31:0] rsp_longitude_e7;
   logic [13:0] rsp_hdop_centi;
   logic [19:0] rsp_time_hhmmss;

   nmea_gga_fix_parser dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_rx_byte(req_rx_byte),
      .empty(empty), .pop(pop), .rsp_fix_valid(rsp_fix_valid),
      .rsp_latitude_e7(rsp_latitude_e7), .rsp_longitude_e7(rsp_longitude_e7),
      .rsp_hdop_centi(rsp_hdop_centi), .rsp_time_hhmmss(rsp_time_hhmmss)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   fix_rec_type     expected_fixes[$];
   int              errors = 0;
   int              idle_cycles = 0;
   bit              calm = 1'b0;
   bit              hold_rx = 1'b0;
   bit              hold_req = 1'b0;

   // line scanner model
   int              ln_len, ln_field, ln_chars;
   bit              hdr_ok, syn_ok;
   int unsigned     tm_acc;
   longint unsigned coord_acc[2];
   bit              lat_neg, lon_neg;
   bit              q_nonzero, q_clean;
   int unsigned     h_whole, h_frac;
   ngfp_pkg::scan_phase_type sc_phase;
   int              sc_frac;
   bit              sc_neg, sc_digit;

   function automatic longint unsigned ten_pow(int n);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < n; i++) p = p * 10;
      return p;
   endfunction

   function automatic void scan_reset();
      sc_phase = ngfp_pkg::PH_LEAD; sc_frac = 0; sc_neg = 0; sc_digit = 0;
   endfunction

   function automatic void line_reset();
      ln_len = 0; ln_field = 0; ln_chars = 0; hdr_ok = 0; syn_ok = 0;
      tm_acc = 0; coord_acc[0] = 0; coord_acc[1] = 0; lat_neg = 0; lon_neg = 0;
      q_nonzero = 0; q_clean = 0; h_whole = 0; h_frac = 0;
      scan_reset();
   endfunction

   // 1 = integer digit, 2 = fraction digit, 0 = anything else
   function automatic int scan_byte(logic [7:0] c, bit allow_frac);
      bit dig;
      dig = c >= "0" && c <= "9";
      if (sc_phase == ngfp_pkg::PH_LEAD) begin
         if (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C) return 0;
         sc_phase = ngfp_pkg::PH_SIGNED;
         if (c == "+" || c == "-") begin
            sc_neg = (c == "-");
            return 0;
         end
      end
      if (sc_phase == ngfp_pkg::PH_SIGNED || sc_phase == ngfp_pkg::PH_INT) begin
         if (dig) begin
            sc_phase = ngfp_pkg::PH_INT; sc_digit = 1; return 1;
         end
         if (c == "." && allow_frac) begin
            sc_phase = ngfp_pkg::PH_FRAC; return 0;
         end
         sc_phase = ngfp_pkg::PH_STOP;
         return 0;
      end
      if (sc_phase == ngfp_pkg::PH_FRAC) begin
         if (dig) begin
            sc_digit = 1; return 2;
         end
         sc_phase = ngfp_pkg::PH_STOP;
      end
      return 0;
   endfunction

   function automatic void coord_add(int idx, int kind, longint unsigned d);
      longint unsigned a, w;
      a = coord_acc[idx];
      if (kind == 1) begin
         w = d * ten_pow(FRAC_DIGITS);
         a = (a > (ACC_CAP - w) / 10) ? ACC_CAP : a * 10 + w;
      end else if (kind == 2) begin
         if (sc_frac < FRAC_DIGITS) begin
            w = d * ten_pow(FRAC_DIGITS - 1 - sc_frac);
            a = (a > ACC_CAP - w) ? ACC_CAP : a + w;
         end
         if (sc_frac < 255) sc_frac++;
      end
      coord_acc[idx] = a;
   endfunction

   function automatic longint unsigned to_e7(longint unsigned acc, longint unsigned lim);
      longint unsigned p, unit, mag;
      p = ten_pow(FRAC_DIGITS);
      unit = 100 * p;
      mag = (acc / unit) * 64'd10000000 + ((acc % unit) * 64'd10000000 + 30 * p) / (60 * p);
      return mag > lim ? lim : mag;
   endfunction

   function automatic void field_close();
      int lim;
      lim = (ln_field == 2 || ln_field == 4) ? 1 : ngfp_pkg::FIELD_LIMIT;
      if (ln_field <= 4) begin
         if (ln_chars == 0 || ln_chars > lim) syn_ok = 0;
         if (ln_field == 0 && sc_neg) tm_acc = 0;
         if (ln_field == 1 && sc_neg) lat_neg = !lat_neg;
         if (ln_field == 3 && sc_neg) lon_neg = !lon_neg;
      end else if (ln_field == 5) begin
         if (ln_chars > ngfp_pkg::FIELD_LIMIT || !sc_digit) syn_ok = 0;
         q_clean = (sc_phase == ngfp_pkg::PH_INT);
      end
      ln_field++;
      ln_chars = 0;
      scan_reset();
   endfunction

   function automatic void field_char(logic [7:0] c);
      int k;
      int unsigned d;
      d = 32'(c - 8'h30);
      if (ln_field == 6) begin
         k = scan_byte(c, 1);
         if (k == 1) begin
            h_whole = h_whole * 10 + d;
            if (h_whole > 100) h_whole = 100;
         end else if (k == 2) begin
            if (sc_frac == 0) h_frac = h_frac + d * 10;
            else if (sc_frac == 1) h_frac = h_frac + d;
            if (sc_frac < 255) sc_frac++;
         end
         return;
      end
      if (ln_field > 6) return;
      if (c == ",") begin
         field_close();
         return;
      end
      if (ln_field == 2 && ln_chars == 0 && c == "S") lat_neg = !lat_neg;
      if (ln_field == 4 && ln_chars == 0 && c == "W") lon_neg = !lon_neg;
      if (ln_chars <= ngfp_pkg::FIELD_LIMIT) ln_chars++;
      if (ln_field == 0) begin
         if (scan_byte(c, 0) == 1) begin
            tm_acc = tm_acc * 10 + d;
            if (tm_acc > ngfp_pkg::TIME_MAX) tm_acc = ngfp_pkg::TIME_MAX;
         end
      end else if (ln_field == 1 || ln_field == 3) begin
         k = scan_byte(c, 1);
         coord_add(ln_field == 1 ? 0 : 1, k, d);
      end else if (ln_field == 5) begin
         if (scan_byte(c, 0) == 1 && d != 0) q_nonzero = 1;
      end
   endfunction

   // returns 1 and fills rec when the byte ends a GGA line
   function automatic bit predict_byte(logic [7:0] c, output fix_rec_type rec);
      bit ok;
      longint unsigned m;
      rec = '0;
      if (c == 8'h0D) return 0;
      if (c == 8'h0A) begin
         ok = hdr_ok && ln_len > 6;
         if (ok) begin
            if (ln_field == 5) field_close();
            rec.fix = syn_ok && ln_field >= 6 && q_nonzero;
            if (rec.fix) begin
               m = to_e7(coord_acc[0], 64'd900000000);
               rec.lat = 31'(lat_neg ? -m : m);
               m = to_e7(coord_acc[1], 64'd1800000000);
               rec.lon = 32'(lon_neg ? -m : m);
               rec.tm = 20'(tm_acc);
               if (q_clean && sc_digit && !sc_neg) begin
                  m = h_whole * 100 + h_frac;
                  rec.hdop = 14'(m > ngfp_pkg::HDOP_MAX ? ngfp_pkg::HDOP_MAX : m);
               end
            end
         end
         line_reset();
         return ok;
      end
      if (ln_len >= ngfp_pkg::LINE_LIMIT - 1) return 0;
      if (ln_len < 6) begin
         case (ln_len)
            0: ok = c == "$";
            1: ok = c == "G";
            2: ok = c == "P" || c == "N";
            5: ok = c == "A";
            default: ok = c == "G";
         endcase
         if (ln_len == 0) begin
            hdr_ok = ok; syn_ok = 0;
         end else if (!ok) begin
            hdr_ok = 0;
         end
      end else if (ln_len == 6) begin
         if (c == ",") syn_ok = 1;
      end else if (syn_ok) begin
         field_char(c);
      end
      ln_len++;
      return 0;
   endfunction

   task automatic send_byte(logic [7:0] c);
      fix_rec_type rec;
      push <= 1'b1;
      req_rx_byte <= c;
      do @(posedge clock); while (!(push && !full));
      if (predict_byte(c, rec)) expected_fixes.push_back(rec);
      if (!calm && $urandom_range(99) < 32) begin
         push <= 1'b0;
         req_rx_byte <= 8'($urandom);
         @(posedge clock);
      end
   endtask

   task automatic send_line(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic string rnd_digits(int n);
      string s;
      s = "";
      for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
      return s;
   endfunction

   function automatic string rnd_field(int kind);
      string s;
      int sel;
      sel = $urandom_range(99);
      if (sel < 80) begin
         case (kind)
            0: s = {rnd_digits($urandom_range(6, 1)), ".", rnd_digits($urandom_range(2))};
            1: s = {rnd_digits($urandom_range(4, 1)), ".", rnd_digits($urandom_range(8))};
            2: s = $urandom_range(1) ? "N" : "S";
            3: s = {rnd_digits($urandom_range(5, 1)), ".", rnd_digits($urandom_range(8))};
            4: s = $urandom_range(1) ? "E" : "W";
            5: s = rnd_digits($urandom_range(2, 1));
            default: s = {rnd_digits($urandom_range(3, 1)), ".", rnd_digits($urandom_range(3))};
         endcase
      end else if (sel < 86) begin
         s = "";
      end else if (sel < 92) begin
         s = {(($urandom_range(1)) ? " -" : "+"), rnd_digits($urandom_range(20, 1))};
      end else begin
         s = "";
         repeat ($urandom_range(4, 1)) s = {s, string'(8'($urandom_range(255)))};
      end
      return s;
   endfunction

   function automatic string rnd_line();
      string s;
      int nf;
      s = $urandom_range(1) ? "$GPGGA" : "$GNGGA";
      if ($urandom_range(99) < 8) s[$urandom_range(5)] = 8'($urandom_range(255));
      if ($urandom_range(99) < 5) return {s, "\n"};
      s = {s, ","};
      nf = $urandom_range(99) < 85 ? 8 : $urandom_range(8);
      for (int f = 0; f < nf; f++) s = {s, rnd_field(f), ","};
      if ($urandom_range(99) < 50) s = {s, "M,0.0,M,,*47"};
      if ($urandom_range(99) < 30) s = {s, "\r"};
      if ($urandom_range(99) < 3) repeat (130) s = {s, "9"};
      return {s, "\n"};
   endfunction

   always @(posedge clock) begin
      fix_rec_type want;
      if (!reset && pop && !empty) begin
         if (expected_fixes.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
         end else begin
            want = expected_fixes.pop_front();
            if (rsp_fix_valid !== want.fix) begin
               $error("fix_valid exp %0d got %0d", want.fix, rsp_fix_valid); errors++;
            end
            if (rsp_latitude_e7 !== want.lat) begin
               $error("latitude_e7 exp %0d got %0d", $signed(want.lat), rsp_latitude_e7);
               errors++;
            end
            if (rsp_longitude_e7 !== want.lon) begin
               $error("longitude_e7 exp %0d got %0d", $signed(want.lon), rsp_longitude_e7);
               errors++;
            end
            if (rsp_hdop_centi !== want.hdop) begin
               $error("hdop_centi exp %0d got %0d", want.hdop, rsp_hdop_centi); errors++;
            end
            if (rsp_time_hhmmss !== want.tm) begin
               $error("time_hhmmss exp %0d got %0d", want.tm, rsp_time_hhmmss); errors++;
            end
         end
      end
      pop <= !hold_rx && (calm || $urandom_range(99) >= 24);
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_nmea_gga_fix_parser NOT OK");
         $finish;
      end
   end

   directed_row_type rows[$];

   initial begin
      fix_rec_type rec;
      int lines;
      line_reset();
      rows = '{
         '{"$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n", 1'b1,
           '{1'b1, 31'd481173000, 32'd115166667, 14'd800, 20'd123519}},
         '{"$GNGGA,000000,0000.000,S,00000.0,W,0,00,1.0\n", 1'b1, '0},
         '{"$GPGGA,999999999,9999.99999,N,99999.99999,E,9,999.99\n", 1'b1,
           '{1'b1, 31'd900000000, 32'd1800000000, 14'd9999, 20'd999999}},
         '{"$GPGGA,,4807.0,N,01131.0,E,1,08,0.9\n", 1'b1, '0},
         '{"$GPGGA,1,4807.0,NN,01131.0,E,1,08,0.9\n", 1'b1, '0},
         '{"$GPGGA,1,1234567890123456,N,1,E,1,8,1\n", 1'b1, '0},
         '{"$GPGGA,1,2\n", 1'b1, '0},
         '{"$GPGGA\n", 1'b0, '0},
         '{"$GPRMC,1,2,3\n", 1'b0, '0},
         '{"\n", 1'b0, '0},
         '{"$GPGGA,-5, -4807.5,S,+01131.5,W,1,08,-1.5\n", 1'b0, '0},
         '{"$GNGGA,1,4807.123456789,N,1.5,W,1x,08,0.9\n", 1'b0, '0},
         '{"$GPGGA,\t12a,4807.0,N,01131.0,E, +2,08,12.345abc\n", 1'b0, '0},
         '{"$GPGGA,1,1,N,1,E,1\n", 1'b0, '0},
         '{"$GPGGA,1,1,N,1,E,,08\n", 1'b0, '0},
         '{"$GPGGA,1,1,S,1,W,3,08,\000\n", 1'b0, '0}
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         send_line(rows[i].text);
         if (rows[i].has_fix) begin
            rec = expected_fixes[$];
            if (rec !== rows[i].rec) begin
               $error("row %0d table exp %h model %h", i, rows[i].rec, rec);
               errors++;
            end
         end
      end
      lines = 0;
      while (lines < 8) begin
         send_line(rnd_line());
         lines++;
      end
      // back-pressure: receiver stalls while the sender keeps pushing
      hold_req = 1'b1;
      for (int i = 0; i < 8; i++) send_line("$GPGGA,1,1,N,1,E,1,1,1\n");
      calm = 1'b1;
      for (int i = 0; i < 5; i++) send_line(rnd_line());
      calm = 1'b0;
      repeat (12) send_byte(8'($urandom));
      send_byte(8'h0A);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h0A);
      for (int i = 0; i < 3; i++) send_line(rnd_line());
      push <= 1'b0;
      while (expected_fixes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("tb_nmea_gga_fix_parser OK");
      else $display("tb_nmea_gga_fix_parser NOT OK");
      $finish;
   end

   initial begin
      wait (hold_req);
      hold_rx = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rx = 1'b0;
   end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/ngfp_pkg.sv
rtl/ngfp_front.sv
rtl/ngfp_queue.sv
rtl/ngfp_back.sv
rtl/nmea_gga_fix_parser.sv
test/tb_nmea_gga_fix_parser.sv
